// ----- hdl/maxcut_flip_gain_engine_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared macros for the concurrent checks of the flip gain engine.
// ----------------------------------------------------------------------------
`ifndef MAXCUT_FLIP_GAIN_ENGINE_ASSERT_SVH
`define MAXCUT_FLIP_GAIN_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MFGE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("flip gain engine check failed");

// Next-cycle implication, disabled during reset.
`define MFGE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("flip gain engine check failed");

`endif

// ----- hdl/mfge_pkg.sv -----
// ----------------------------------------------------------------------------
// mfge_pkg
// Types and constants shared by the flip gain engine modules.
// ----------------------------------------------------------------------------
package mfge_pkg;

    // Request kinds; unknown codes are folded into a read by the front end.
    typedef enum logic [2:0] {
        REQ_LOAD  = 3'd0,
        REQ_EDGE  = 3'd1,
        REQ_FLIP  = 3'd2,
        REQ_READ  = 3'd3,
        REQ_CLEAR = 3'd4
    } req_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_FULL        = 2'd1,
        ST_FIXED_FLIP  = 2'd2,
        ST_WRONG_SPIN  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_E_RDB,
        S_E_CAP,
        S_E_WRB,
        S_F_CAP,
        S_SCAN,
        S_NB_WAIT,
        S_CLEAR,
        S_FIN_RD,
        S_FIN_CAP
    } state_t;

    // Classification of one request, passed from front end to back end.
    typedef struct packed {
        req_t kind;
        logic n_ok;
        logic o_ok;
        logic n_zero;
        logic spin;
    } cmd_flags_t;

    localparam int IDX_BITS    = 10;
    localparam int WIN_BITS    = 16;
    localparam int GAIN_BITS   = 32;
    localparam int CUT_BITS    = 36;
    localparam int S_DATA_BITS = 40;
    localparam int M_DATA_BITS = 72;

    // Input word layout
    localparam int S_NODE_LSB  = 0;
    localparam int S_OTHER_LSB = 10;
    localparam int S_SPIN_BIT  = 20;
    localparam int S_W_LSB     = 21;

    // Output word layout
    localparam int M_CUT_LSB   = 0;
    localparam int M_SPIN_BIT  = 36;
    localparam int M_GAIN_LSB  = 37;

endpackage

// ----- hdl/mfge_ram.sv -----
// ----------------------------------------------------------------------------
// mfge_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mfge_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/mfge_front.sv -----
// ----------------------------------------------------------------------------
// mfge_front
// Accepts request words, checks ranges and packs a command for the queue.
// ----------------------------------------------------------------------------
module mfge_front #(
    parameter int MAX_NODES   = 1024,
    parameter int WEIGHT_BITS = 16,
    localparam int NA = $clog2(MAX_NODES),
    localparam int WB = (WEIGHT_BITS < 16) ? WEIGHT_BITS : 16,
    localparam int FW = $bits(mfge_pkg::cmd_flags_t),
    localparam int QW = FW + 2 * NA + WB
) (
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [mfge_pkg::S_DATA_BITS-1:0]   s_tdata,
    input  logic [2:0]                         s_tuser,
    input  logic                               enable,
    input  logic                               q_full,
    output logic                               push,
    output logic [QW-1:0]                      cmd
);

    logic [mfge_pkg::IDX_BITS-1:0] node_idx;
    logic [mfge_pkg::IDX_BITS-1:0] other_idx;
    logic [mfge_pkg::WIN_BITS-1:0] weight;
    mfge_pkg::cmd_flags_t          flags;

    assign node_idx  = s_tdata[mfge_pkg::S_NODE_LSB +: mfge_pkg::IDX_BITS];
    assign other_idx = s_tdata[mfge_pkg::S_OTHER_LSB +: mfge_pkg::IDX_BITS];
    assign weight    = s_tdata[mfge_pkg::S_W_LSB +: mfge_pkg::WIN_BITS];

    always_comb
    begin
        if (s_tuser <= 3'(mfge_pkg::REQ_CLEAR))
        begin
            flags.kind = mfge_pkg::req_t'(s_tuser);
        end
        else
        begin
            // Unknown codes only report the addressed node.
            flags.kind = mfge_pkg::REQ_READ;
        end
        flags.n_ok   = 32'(node_idx) < MAX_NODES;
        flags.o_ok   = 32'(other_idx) < MAX_NODES;
        flags.n_zero = (node_idx == '0);
        flags.spin   = s_tdata[mfge_pkg::S_SPIN_BIT];
    end

    assign s_tready = enable && !q_full;
    assign push     = s_tvalid && s_tready;
    assign cmd      = {weight[WB-1:0], NA'(other_idx), NA'(node_idx), flags};

endmodule

// ----- hdl/mfge_queue.sv -----
// ----------------------------------------------------------------------------
// mfge_queue
// Two-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module mfge_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic             full,
    output logic             valid,
    output logic [WIDTH-1:0] head
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wp_reg;
    logic             wp_next;
    logic             rp_reg;
    logic             rp_next;
    logic [1:0]       cnt_reg;
    logic [1:0]       cnt_next;

    always_comb
    begin
        wp_next  = wp_reg ^ push;
        rp_next  = rp_reg ^ pop;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wp_reg] <= push_data;
        end
    end

    assign full  = (cnt_reg == 2'd2);
    assign valid = (cnt_reg != 2'd0);
    assign head  = slot_reg[rp_reg];

endmodule

// ----- hdl/mfge_back.sv -----
// ----------------------------------------------------------------------------
// mfge_back
// Executes commands on the spin, gain and edge memories and holds the result.
// ----------------------------------------------------------------------------
module mfge_back #(
    parameter int MAX_NODES   = 1024,
    parameter int MAX_EDGES   = 4096,
    parameter int WEIGHT_BITS = 16,
    localparam int NA = $clog2(MAX_NODES),
    localparam int WB = (WEIGHT_BITS < 16) ? WEIGHT_BITS : 16,
    localparam int FW = $bits(mfge_pkg::cmd_flags_t),
    localparam int QW = FW + 2 * NA + WB,
    localparam int EA = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
    localparam int CW = $clog2(MAX_EDGES + 1),
    localparam int EW = 2 * NA + WB
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_valid,
    input  logic [QW-1:0]                     q_data,
    output logic                              q_pop,
    input  logic                              first_node_fixed,
    input  logic                              fixed_first_spin,
    output logic                              init_busy,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mfge_pkg::M_DATA_BITS-1:0]  m_tdata,
    output logic [1:0]                        m_tuser
);

    localparam int GB = mfge_pkg::GAIN_BITS;
    localparam int CB = mfge_pkg::CUT_BITS;

    mfge_pkg::state_t     state_reg;
    mfge_pkg::state_t     state_next;

    mfge_pkg::cmd_flags_t q_flags;
    logic [NA-1:0]        q_n;
    logic [NA-1:0]        q_o;
    logic [WB-1:0]        q_w;

    mfge_pkg::cmd_flags_t flags_reg;
    mfge_pkg::cmd_flags_t flags_next;
    logic [NA-1:0]        n_reg;
    logic [NA-1:0]        n_next;
    logic [NA-1:0]        o_reg;
    logic [NA-1:0]        o_next;
    logic [WB-1:0]        w_reg;
    logic [WB-1:0]        w_next;
    mfge_pkg::status_t    status_reg;
    mfge_pkg::status_t    status_next;
    logic [CB-1:0]        cut_reg;
    logic [CB-1:0]        cut_next;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic [NA-1:0]        ptr_reg;
    logic [NA-1:0]        ptr_next;
    logic [CW-1:0]        scan_reg;
    logic [CW-1:0]        scan_next;
    logic                 evld_reg;
    logic                 evld_next;
    logic [NA-1:0]        other_reg;
    logic [NA-1:0]        other_next;
    logic [GB-1:0]        dw_reg;
    logic [GB-1:0]        dw_next;
    logic                 newspin_reg;
    logic                 newspin_next;
    logic                 sn_reg;
    logic                 sn_next;
    logic [GB-1:0]        gn_reg;
    logic [GB-1:0]        gn_next;
    logic [GB-1:0]        gb_reg;
    logic [GB-1:0]        gb_next;

    logic                 out_vld_reg;
    logic                 out_vld_next;
    mfge_pkg::status_t    out_status_reg;
    mfge_pkg::status_t    out_status_next;
    logic [CB-1:0]        out_cut_reg;
    logic [CB-1:0]        out_cut_next;
    logic                 out_spin_reg;
    logic                 out_spin_next;
    logic [GB-1:0]        out_gain_reg;
    logic [GB-1:0]        out_gain_next;

    // Node memory controls (spin and gain share addresses)
    logic                 spin_we;
    logic                 gain_we;
    logic [NA-1:0]        node_waddr;
    logic                 spin_wdata;
    logic [GB-1:0]        gain_wdata;
    logic                 node_re;
    logic [NA-1:0]        node_raddr;
    logic                 spin_rd;
    logic [GB-1:0]        gain_rd;

    logic                 edge_we;
    logic [EW-1:0]        edge_wdata;
    logic                 edge_re;
    logic [EW-1:0]        edge_rd;
    logic [NA-1:0]        ed_a;
    logic [NA-1:0]        ed_b;
    logic [WB-1:0]        ed_w;

    logic [GB-1:0]        w32;
    logic [GB-1:0]        delta;
    logic                 edge_full;
    logic                 ptr_last;
    logic                 out_free;
    logic                 ed_match;

    assign q_flags = mfge_pkg::cmd_flags_t'(q_data[FW-1:0]);
    assign q_n     = q_data[FW +: NA];
    assign q_o     = q_data[FW+NA +: NA];
    assign q_w     = q_data[FW+2*NA +: WB];

    assign ed_a = edge_rd[0 +: NA];
    assign ed_b = edge_rd[NA +: NA];
    assign ed_w = edge_rd[2*NA +: WB];

    assign w32       = GB'($signed(w_reg));
    assign delta     = (sn_reg != spin_rd) ? (GB'(0) - w32) : w32;
    assign edge_full = (count_reg == CW'(MAX_EDGES));
    assign ptr_last  = (ptr_reg == NA'(MAX_NODES - 1));
    assign out_free  = !out_vld_reg || m_tready;
    assign ed_match  = evld_reg && ((ed_a == n_reg) || (ed_b == n_reg));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mfge_pkg::S_INIT:
            begin
                if (ptr_last)
                begin
                    state_next = mfge_pkg::S_IDLE;
                end
            end
            mfge_pkg::S_IDLE:
            begin
                if (q_valid)
                begin
                    unique case (q_flags.kind)
                        mfge_pkg::REQ_EDGE:
                        begin
                            if (q_flags.n_ok && q_flags.o_ok && !edge_full)
                            begin
                                state_next = mfge_pkg::S_E_RDB;
                            end
                            else
                            begin
                                state_next = mfge_pkg::S_FIN_RD;
                            end
                        end
                        mfge_pkg::REQ_FLIP:
                        begin
                            if (q_flags.n_ok && !(first_node_fixed && q_flags.n_zero))
                            begin
                                state_next = mfge_pkg::S_F_CAP;
                            end
                            else
                            begin
                                state_next = mfge_pkg::S_FIN_RD;
                            end
                        end
                        mfge_pkg::REQ_CLEAR:
                        begin
                            state_next = mfge_pkg::S_CLEAR;
                        end
                        default:
                        begin
                            state_next = mfge_pkg::S_FIN_RD;
                        end
                    endcase
                end
            end
            mfge_pkg::S_E_RDB:   state_next = mfge_pkg::S_E_CAP;
            mfge_pkg::S_E_CAP:   state_next = mfge_pkg::S_E_WRB;
            mfge_pkg::S_E_WRB:   state_next = mfge_pkg::S_FIN_RD;
            mfge_pkg::S_F_CAP:   state_next = mfge_pkg::S_SCAN;
            mfge_pkg::S_SCAN:
            begin
                if (ed_match)
                begin
                    state_next = mfge_pkg::S_NB_WAIT;
                end
                else if (!evld_reg && (scan_reg == count_reg))
                begin
                    state_next = mfge_pkg::S_FIN_RD;
                end
            end
            mfge_pkg::S_NB_WAIT: state_next = mfge_pkg::S_SCAN;
            mfge_pkg::S_CLEAR:
            begin
                if (ptr_last)
                begin
                    state_next = mfge_pkg::S_FIN_RD;
                end
            end
            mfge_pkg::S_FIN_RD:  state_next = mfge_pkg::S_FIN_CAP;
            mfge_pkg::S_FIN_CAP:
            begin
                if (out_free)
                begin
                    state_next = mfge_pkg::S_IDLE;
                end
            end
            default:             state_next = mfge_pkg::S_IDLE;
        endcase
    end

    // Datapath and memory controls
    always_comb
    begin
        flags_next      = flags_reg;
        n_next          = n_reg;
        o_next          = o_reg;
        w_next          = w_reg;
        status_next     = status_reg;
        cut_next        = cut_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        scan_next       = scan_reg;
        evld_next       = evld_reg;
        other_next      = other_reg;
        dw_next         = dw_reg;
        newspin_next    = newspin_reg;
        sn_next         = sn_reg;
        gn_next         = gn_reg;
        gb_next         = gb_reg;
        out_status_next = out_status_reg;
        out_cut_next    = out_cut_reg;
        out_spin_next   = out_spin_reg;
        out_gain_next   = out_gain_reg;
        out_vld_next    = out_vld_reg && !m_tready;

        q_pop      = 1'b0;
        spin_we    = 1'b0;
        gain_we    = 1'b0;
        node_waddr = n_reg;
        spin_wdata = 1'b0;
        gain_wdata = '0;
        node_re    = 1'b0;
        node_raddr = n_reg;
        edge_we    = 1'b0;
        edge_wdata = {w_reg, o_reg, n_reg};
        edge_re    = 1'b0;

        unique case (state_reg)
            mfge_pkg::S_INIT:
            begin
                spin_we    = 1'b1;
                gain_we    = 1'b1;
                node_waddr = ptr_reg;
                ptr_next   = ptr_reg + NA'(1);
            end
            mfge_pkg::S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop       = 1'b1;
                    flags_next  = q_flags;
                    n_next      = q_n;
                    o_next      = q_o;
                    w_next      = q_w;
                    status_next = mfge_pkg::ST_OK;
                    ptr_next    = '0;
                    unique case (q_flags.kind)
                        mfge_pkg::REQ_LOAD:
                        begin
                            if (q_flags.n_ok)
                            begin
                                if (first_node_fixed && q_flags.n_zero &&
                                    (q_flags.spin != fixed_first_spin))
                                begin
                                    status_next = mfge_pkg::ST_WRONG_SPIN;
                                end
                                else
                                begin
                                    spin_we    = 1'b1;
                                    node_waddr = q_n;
                                    spin_wdata = q_flags.spin;
                                end
                            end
                        end
                        mfge_pkg::REQ_EDGE:
                        begin
                            if (q_flags.n_ok && q_flags.o_ok)
                            begin
                                if (edge_full)
                                begin
                                    status_next = mfge_pkg::ST_FULL;
                                end
                                else
                                begin
                                    node_re    = 1'b1;
                                    node_raddr = q_n;
                                end
                            end
                        end
                        mfge_pkg::REQ_FLIP:
                        begin
                            if (q_flags.n_ok)
                            begin
                                if (first_node_fixed && q_flags.n_zero)
                                begin
                                    status_next = mfge_pkg::ST_FIXED_FLIP;
                                end
                                else
                                begin
                                    node_re    = 1'b1;
                                    node_raddr = q_n;
                                end
                            end
                        end
                        mfge_pkg::REQ_CLEAR:
                        begin
                            cut_next   = '0;
                            count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            mfge_pkg::S_E_RDB:
            begin
                sn_next    = spin_rd;
                gn_next    = gain_rd;
                node_re    = 1'b1;
                node_raddr = o_reg;
            end
            mfge_pkg::S_E_CAP:
            begin
                // Second endpoint's data is on the read port now.
                gain_we    = 1'b1;
                node_waddr = n_reg;
                gain_wdata = gn_reg + delta;
                if (n_reg == o_reg)
                begin
                    gb_next = gn_reg + delta + delta;
                end
                else
                begin
                    gb_next = gain_rd + delta;
                end
                if (sn_reg != spin_rd)
                begin
                    cut_next = cut_reg + CB'($signed(w_reg));
                end
                edge_we    = 1'b1;
                count_next = count_reg + CW'(1);
            end
            mfge_pkg::S_E_WRB:
            begin
                gain_we    = 1'b1;
                node_waddr = o_reg;
                gain_wdata = gb_reg;
            end
            mfge_pkg::S_F_CAP:
            begin
                cut_next     = cut_reg + CB'($signed(gain_rd));
                newspin_next = !spin_rd;
                spin_we      = 1'b1;
                gain_we      = 1'b1;
                node_waddr   = n_reg;
                spin_wdata   = !spin_rd;
                gain_wdata   = GB'(0) - gain_rd;
                scan_next    = '0;
                evld_next    = 1'b0;
            end
            mfge_pkg::S_SCAN:
            begin
                // Edge reads stream one per cycle until an incident edge shows up.
                if (ed_match)
                begin
                    other_next = (ed_a == n_reg) ? ed_b : ed_a;
                    dw_next    = GB'($signed(ed_w)) << 1;
                    node_re    = 1'b1;
                    node_raddr = (ed_a == n_reg) ? ed_b : ed_a;
                    evld_next  = 1'b0;
                end
                else if (scan_reg != count_reg)
                begin
                    edge_re   = 1'b1;
                    scan_next = scan_reg + CW'(1);
                    evld_next = 1'b1;
                end
                else
                begin
                    evld_next = 1'b0;
                end
            end
            mfge_pkg::S_NB_WAIT:
            begin
                gain_we    = 1'b1;
                node_waddr = other_reg;
                if (spin_rd == newspin_reg)
                begin
                    gain_wdata = gain_rd + dw_reg;
                end
                else
                begin
                    gain_wdata = gain_rd - dw_reg;
                end
            end
            mfge_pkg::S_CLEAR:
            begin
                gain_we    = 1'b1;
                node_waddr = ptr_reg;
                ptr_next   = ptr_reg + NA'(1);
            end
            mfge_pkg::S_FIN_RD:
            begin
                node_re = 1'b1;
            end
            mfge_pkg::S_FIN_CAP:
            begin
                if (out_free)
                begin
                    out_vld_next    = 1'b1;
                    out_status_next = status_reg;
                    out_cut_next    = cut_reg;
                    out_spin_next   = flags_reg.n_ok ? spin_rd : 1'b0;
                    out_gain_next   = flags_reg.n_ok ? gain_rd : '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= mfge_pkg::S_INIT;
            ptr_reg     <= '0;
            count_reg   <= '0;
            cut_reg     <= '0;
            scan_reg    <= '0;
            evld_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ptr_reg     <= ptr_next;
            count_reg   <= count_next;
            cut_reg     <= cut_next;
            scan_reg    <= scan_next;
            evld_reg    <= evld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        flags_reg      <= flags_next;
        n_reg          <= n_next;
        o_reg          <= o_next;
        w_reg          <= w_next;
        status_reg     <= status_next;
        other_reg      <= other_next;
        dw_reg         <= dw_next;
        newspin_reg    <= newspin_next;
        sn_reg         <= sn_next;
        gn_reg         <= gn_next;
        gb_reg         <= gb_next;
        out_status_reg <= out_status_next;
        out_cut_reg    <= out_cut_next;
        out_spin_reg   <= out_spin_next;
        out_gain_reg   <= out_gain_next;
    end

    mfge_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_spin_ram (
        .clk     (clk),
        .wr_en   (spin_we),
        .wr_addr (node_waddr),
        .wr_data (spin_wdata),
        .rd_en   (node_re),
        .rd_addr (node_raddr),
        .rd_data (spin_rd)
    );

    mfge_ram #(.WIDTH(GB), .DEPTH(MAX_NODES)) u_gain_ram (
        .clk     (clk),
        .wr_en   (gain_we),
        .wr_addr (node_waddr),
        .wr_data (gain_wdata),
        .rd_en   (node_re),
        .rd_addr (node_raddr),
        .rd_data (gain_rd)
    );

    mfge_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edge_ram (
        .clk     (clk),
        .wr_en   (edge_we),
        .wr_addr (count_reg[EA-1:0]),
        .wr_data (edge_wdata),
        .rd_en   (edge_re),
        .rd_addr (scan_reg[EA-1:0]),
        .rd_data (edge_rd)
    );

    assign init_busy = (state_reg == mfge_pkg::S_INIT);
    assign m_tvalid  = out_vld_reg;
    assign m_tuser   = out_status_reg;
    assign m_tdata   = {3'b000, out_gain_reg, out_spin_reg, out_cut_reg};

endmodule

// ----- hdl/maxcut_flip_gain_engine.sv -----
// ----------------------------------------------------------------------------
// maxcut_flip_gain_engine
// Weighted max-cut state keeper with incremental one-flip gains.
// ----------------------------------------------------------------------------
// Each accepted request word yields exactly one result word. A flip walks the
// edge memory through its single read port, one stored edge per cycle while no
// incident edge is found; each edge that touches the flipped node pauses the
// walk to update the gain of its other end. After reset a clearing pass zeroes
// the spin and gain memories and no request is taken until it ends;
// configuration writes are taken at any time. A two-entry queue sits between
// the request side and the executing back end, and the result sits in an
// output register, so requests keep being taken while a result waits, until
// the queue is full.
module maxcut_flip_gain_engine #(
    parameter int MAX_NODES   = 1024,
    parameter int MAX_EDGES   = 4096,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // node_index[9:0], other_node[19:10], spin[20], edge_weight[36:21], zero pad
    input  logic [mfge_pkg::S_DATA_BITS-1:0]  s_tdata,
    // req_type[2:0]
    input  logic [2:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // cut_weight[35:0], node_spin[36], node_gain[68:37], zero pad
    output logic [mfge_pkg::M_DATA_BITS-1:0]  m_tdata,
    // status[1:0]
    output logic [1:0]                        m_tuser,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [0:0]                        cfg_index,
    input  logic [0:0]                        cfg_data
);

    localparam int NA = $clog2(MAX_NODES);
    localparam int WB = (WEIGHT_BITS < 16) ? WEIGHT_BITS : 16;
    localparam int FW = $bits(mfge_pkg::cmd_flags_t);
    localparam int QW = FW + 2 * NA + WB;

    localparam logic [0:0] CFG_FIRST_FIXED = 1'b0;
    localparam logic [0:0] CFG_FIXED_SPIN  = 1'b1;

    logic          first_fixed_reg;
    logic          fixed_spin_reg;
    logic          init_busy;
    logic          q_full;
    logic          q_valid;
    logic          q_pop;
    logic          push;
    logic [QW-1:0] cmd;
    logic [QW-1:0] q_head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_fixed_reg <= 1'b0;
            fixed_spin_reg  <= 1'b0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_FIRST_FIXED)
            begin
                first_fixed_reg <= cfg_data[0];
            end
            if (cfg_index == CFG_FIXED_SPIN)
            begin
                fixed_spin_reg <= cfg_data[0];
            end
        end
    end

    mfge_front #(
        .MAX_NODES   (MAX_NODES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .enable   (!init_busy),
        .q_full   (q_full),
        .push     (push),
        .cmd      (cmd)
    );

    mfge_queue #(.WIDTH(QW)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (cmd),
        .pop       (q_pop),
        .full      (q_full),
        .valid     (q_valid),
        .head      (q_head)
    );

    mfge_back #(
        .MAX_NODES   (MAX_NODES),
        .MAX_EDGES   (MAX_EDGES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_valid          (q_valid),
        .q_data           (q_head),
        .q_pop            (q_pop),
        .first_node_fixed (first_fixed_reg),
        .fixed_first_spin (fixed_spin_reg),
        .init_busy        (init_busy),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .m_tuser          (m_tuser)
    );

endmodule

// ----- hdl/mfge_checker.sv -----
// ----------------------------------------------------------------------------
// mfge_checker
// Port-level checks of the flip gain engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "maxcut_flip_gain_engine_assert.svh"

module mfge_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [mfge_pkg::S_DATA_BITS-1:0]  s_tdata,
    input logic [2:0]                        s_tuser,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [mfge_pkg::M_DATA_BITS-1:0]  m_tdata,
    input logic [1:0]                        m_tuser,
    input logic                              cfg_valid,
    input logic                              cfg_ready,
    input logic [0:0]                        cfg_index,
    input logic [0:0]                        cfg_data
);

    // A stalled result word must stay put.
    `MFGE_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid)
    `MFGE_ASSERT_NEXT(a_out_stable, clk, rst_n, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser))
    // Register writes are never back-pressured.
    `MFGE_ASSERT_NOW(a_cfg_ready, clk, rst_n, cfg_valid, cfg_ready)
    // The memory clearing pass holds off requests right after reset.
    `MFGE_ASSERT_NOW(a_init_block, clk, rst_n, !$past(rst_n), !s_tready)

endmodule

bind maxcut_flip_gain_engine mfge_checker u_mfge_checker (.*);

// ----- sim/mfge_result_checker.sv -----
// ----------------------------------------------------------------------------
// mfge_result_checker
// Mirrors the spins, gains, edge list and cut of the flip gain engine and
// checks every result word against the oldest predicted one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mfge_result_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [mfge_pkg::S_DATA_BITS-1:0]  s_tdata,
    input  logic [2:0]                        s_tuser,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [mfge_pkg::M_DATA_BITS-1:0]  m_tdata,
    input  logic [1:0]                        m_tuser,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [0:0]                        cfg_index,
    input  logic [0:0]                        cfg_data,
    output int                                fail_count,
    output int                                pending_results
);

    localparam int NODE_COUNT = 1024;
    localparam int EDGE_SLOTS = 4096;
    localparam logic [0:0] CFG_FIXED_EN   = 1'b0;
    localparam logic [0:0] CFG_FIXED_SPIN = 1'b1;

    typedef struct {
        mfge_pkg::status_t             status;
        logic [mfge_pkg::CUT_BITS-1:0] cut;
        logic                          spin;
        logic [31:0]                   gain;
    } node_report_t;

    logic                          node_spin_m [NODE_COUNT];
    logic [31:0]                   node_gain_m [NODE_COUNT];
    logic [9:0]                    edge_from   [EDGE_SLOTS];
    logic [9:0]                    edge_to     [EDGE_SLOTS];
    logic [31:0]                   edge_wt     [EDGE_SLOTS];
    int                            edge_total;
    logic [mfge_pkg::CUT_BITS-1:0] cut_mirror;
    logic                          pin_node0;
    logic                          pin_spin;
    node_report_t                  report_q [$];

    initial
    begin
        for (int k = 0; k < NODE_COUNT; k++)
        begin
            node_spin_m[k] = 1'b0;
            node_gain_m[k] = '0;
        end
        edge_total      = 0;
        cut_mirror      = '0;
        pin_node0       = 1'b0;
        pin_spin        = 1'b0;
        fail_count      = 0;
        pending_results = 0;
    end

    task automatic flip_in_mirror(input logic [9:0] n);
        logic [9:0]  nb;
        logic [31:0] d;
        cut_mirror = cut_mirror + {{4{node_gain_m[n][31]}}, node_gain_m[n]};
        node_spin_m[n] = ~node_spin_m[n];
        node_gain_m[n] = -node_gain_m[n];
        for (int e = 0; e < edge_total; e++)
        begin
            if (edge_from[e] == n)
                nb = edge_to[e];
            else if (edge_to[e] == n)
                nb = edge_from[e];
            else
                continue;
            d = edge_wt[e] << 1;
            if (node_spin_m[n] == node_spin_m[nb])
                node_gain_m[nb] = node_gain_m[nb] + d;
            else
                node_gain_m[nb] = node_gain_m[nb] - d;
        end
    endtask

    task automatic predict_report(input logic [2:0] kind, input logic [9:0] n,
                                  input logic [9:0] o, input logic sp,
                                  input logic [15:0] wraw);
        node_report_t rep;
        logic [31:0]  w;
        w = {{16{wraw[15]}}, wraw};
        rep.status = mfge_pkg::ST_OK;
        case (kind)
            mfge_pkg::REQ_LOAD:
                if (pin_node0 && n == 0 && sp != pin_spin)
                    rep.status = mfge_pkg::ST_WRONG_SPIN;
                else
                    node_spin_m[n] = sp;
            mfge_pkg::REQ_EDGE:
                if (edge_total >= EDGE_SLOTS)
                    rep.status = mfge_pkg::ST_FULL;
                else
                begin
                    edge_from[edge_total] = n;
                    edge_to[edge_total]   = o;
                    edge_wt[edge_total]   = w;
                    edge_total++;
                    if (node_spin_m[n] == node_spin_m[o])
                    begin
                        node_gain_m[n] = node_gain_m[n] + w;
                        node_gain_m[o] = node_gain_m[o] + w;
                    end
                    else
                    begin
                        cut_mirror = cut_mirror + {{4{w[31]}}, w};
                        node_gain_m[n] = node_gain_m[n] - w;
                        node_gain_m[o] = node_gain_m[o] - w;
                    end
                end
            mfge_pkg::REQ_FLIP:
                if (pin_node0 && n == 0)
                    rep.status = mfge_pkg::ST_FIXED_FLIP;
                else
                    flip_in_mirror(n);
            mfge_pkg::REQ_CLEAR:
            begin
                edge_total = 0;
                cut_mirror = '0;
                for (int k = 0; k < NODE_COUNT; k++)
                    node_gain_m[k] = '0;
            end
            default: ;
        endcase
        rep.cut  = cut_mirror;
        rep.spin = node_spin_m[n];
        rep.gain = node_gain_m[n];
        report_q.insert(report_q.size(), rep);
    endtask

    always @(posedge clk)
    begin
        node_report_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (report_q.size() == 0)
                begin
                    $display("%0t: result word with nothing expected: status %0d data %h",
                             $time, m_tuser, m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = report_q.pop_front();
                    if (m_tuser != want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, m_tuser);
                        fail_count++;
                    end
                    if (m_tdata[mfge_pkg::M_CUT_LSB +: mfge_pkg::CUT_BITS] != want.cut)
                    begin
                        $display("%0t: cut expected %0d actual %0d", $time,
                                 $signed(want.cut),
                                 $signed(m_tdata[mfge_pkg::M_CUT_LSB +: mfge_pkg::CUT_BITS]));
                        fail_count++;
                    end
                    if (m_tdata[mfge_pkg::M_SPIN_BIT] != want.spin)
                    begin
                        $display("%0t: spin expected %0d actual %0d",
                                 $time, want.spin, m_tdata[mfge_pkg::M_SPIN_BIT]);
                        fail_count++;
                    end
                    if (m_tdata[mfge_pkg::M_GAIN_LSB +: mfge_pkg::GAIN_BITS] != want.gain)
                    begin
                        $display("%0t: gain expected %0d actual %0d", $time,
                                 $signed(want.gain),
                                 $signed(m_tdata[mfge_pkg::M_GAIN_LSB +: mfge_pkg::GAIN_BITS]));
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_report(s_tuser,
                               s_tdata[mfge_pkg::S_NODE_LSB +: mfge_pkg::IDX_BITS],
                               s_tdata[mfge_pkg::S_OTHER_LSB +: mfge_pkg::IDX_BITS],
                               s_tdata[mfge_pkg::S_SPIN_BIT],
                               s_tdata[mfge_pkg::S_W_LSB +: mfge_pkg::WIN_BITS]);
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_FIXED_EN)
                    pin_node0 = cfg_data;
                else if (cfg_index == CFG_FIXED_SPIN)
                    pin_spin = cfg_data;
            end
        end
        pending_results = report_q.size();
    end

endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Drives request words and register writes into the flip gain engine, with
// random gaps and back-pressure, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam int          RUN_LIMIT     = 2000000;
    localparam int          NODE_LAST     = 1023;
    localparam logic [0:0]  CFG_FIXED_EN  = 1'b0;
    localparam logic [0:0]  CFG_FIXED_SPIN = 1'b1;
    localparam logic [2:0]  REQ_ODD_FIRST = 3'd5;
    localparam logic [2:0]  REQ_ODD_LAST  = 3'd7;

    logic                              clk;
    logic                              rst_n;
    logic                              s_tvalid;
    logic                              s_tready;
    logic [mfge_pkg::S_DATA_BITS-1:0]  s_tdata;
    logic [2:0]                        s_tuser;
    logic                              m_tvalid;
    logic                              m_tready;
    logic [mfge_pkg::M_DATA_BITS-1:0]  m_tdata;
    logic [1:0]                        m_tuser;
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic [0:0]                        cfg_index;
    logic [0:0]                        cfg_data;
    int                                fail_count;
    int                                pending_results;
    int                                cycle_no;
    int                                stall_left;
    logic                              rx_calm;
    logic                              tx_calm;

    maxcut_flip_gain_engine i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    mfge_result_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    initial
        clk = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_no <= cycle_no + 1;
        if (cycle_no > RUN_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side: stalls mostly short, a few long, with calm stretches.
    always @(negedge clk)
    begin
        if ($urandom_range(0, 199) == 0)
            rx_calm <= ~rx_calm;
        if (stall_left > 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (!rx_calm && $urandom_range(0, 99) < 30)
        begin
            m_tready   <= 1'b0;
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 2);
        end
        else
            m_tready <= 1'b1;
    end

    function automatic int gap_after_word();
        int r;
        r = $urandom_range(0, 99);
        if (tx_calm || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_req(input logic [2:0] kind, input logic [9:0] n,
                            input logic [9:0] o, input logic sp,
                            input logic [15:0] w);
        int gap;
        s_tuser  <= kind;
        s_tdata  <= {3'b000, w, sp, o, n};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        gap = gap_after_word();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Holds off until every result has come back, then lets the block settle.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results != 0)
            @(posedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [0:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [9:0] pick_node();
        if ($urandom_range(0, 9) == 0)
            return 10'($urandom_range(0, NODE_LAST));
        return 10'($urandom_range(0, 15));
    endfunction

    task automatic random_req();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            send_req(mfge_pkg::REQ_LOAD, pick_node(), 10'($urandom), 1'($urandom),
                     16'($urandom));
        else if (r < 55)
            send_req(mfge_pkg::REQ_EDGE, pick_node(), pick_node(), 1'($urandom),
                     16'($urandom));
        else if (r < 72)
            send_req(mfge_pkg::REQ_FLIP, pick_node(), 10'($urandom), 1'($urandom),
                     16'($urandom));
        else if (r < 87)
            send_req(mfge_pkg::REQ_READ, pick_node(), 10'($urandom), 1'($urandom),
                     16'($urandom));
        else if (r < 90)
            send_req(mfge_pkg::REQ_CLEAR, pick_node(), 10'($urandom), 1'($urandom),
                     16'($urandom));
        else if (r < 95)
            send_req(3'($urandom_range(REQ_ODD_FIRST, REQ_ODD_LAST)), pick_node(),
                     10'($urandom), 1'($urandom), 16'($urandom));
        else
            send_req(10'($urandom) == 0 ? mfge_pkg::REQ_LOAD : mfge_pkg::REQ_EDGE,
                     10'($urandom), 10'($urandom), 1'($urandom), 16'($urandom));
    endtask

    initial
    begin
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = mfge_pkg::REQ_READ;
        m_tready   = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_FIXED_EN;
        cfg_data   = 1'b0;
        cycle_no   = 0;
        stall_left = 0;
        rx_calm    = 1'b0;
        tx_calm    = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Extremes of nodes and weights, a self loop, every request kind.
        send_req(mfge_pkg::REQ_LOAD, 10'd1023, 10'd0, 1'b1, 16'h0000);
        send_req(mfge_pkg::REQ_LOAD, 10'd1, 10'd1023, 1'b1, 16'hffff);
        send_req(mfge_pkg::REQ_EDGE, 10'd0, 10'd1023, 1'b0, 16'h8000);
        send_req(mfge_pkg::REQ_EDGE, 10'd1023, 10'd1, 1'b1, 16'h7fff);
        send_req(mfge_pkg::REQ_EDGE, 10'd2, 10'd2, 1'b0, 16'h0123);
        send_req(mfge_pkg::REQ_EDGE, 10'd0, 10'd2, 1'b0, 16'hfffe);
        send_req(mfge_pkg::REQ_FLIP, 10'd2, 10'd0, 1'b0, 16'h0000);
        send_req(mfge_pkg::REQ_FLIP, 10'd1023, 10'd0, 1'b0, 16'h0000);
        send_req(mfge_pkg::REQ_READ, 10'd0, 10'd0, 1'b0, 16'h0000);
        send_req(mfge_pkg::REQ_FLIP, 10'd0, 10'd0, 1'b0, 16'h0000);
        send_req(REQ_ODD_FIRST, 10'd1, 10'h3ff, 1'b1, 16'hffff);
        send_req(REQ_ODD_LAST, 10'd1023, 10'd0, 1'b0, 16'h0000);
        // A late spin load only moves the spin.
        send_req(mfge_pkg::REQ_LOAD, 10'd2, 10'd0, 1'b1, 16'h0000);
        send_req(mfge_pkg::REQ_CLEAR, 10'd1, 10'd0, 1'b0, 16'h0000);
        send_req(mfge_pkg::REQ_READ, 10'd1, 10'd0, 1'b0, 16'h0000);
        drain_results();

        // Node 0 pinned to +1: a flip and a wrong load are refused.
        write_reg(CFG_FIXED_EN, 1'b1);
        write_reg(CFG_FIXED_SPIN, 1'b1);
        send_req(mfge_pkg::REQ_FLIP, 10'd0, 10'd0, 1'b0, 16'h0000);
        send_req(mfge_pkg::REQ_LOAD, 10'd0, 10'd0, 1'b0, 16'h0000);
        send_req(mfge_pkg::REQ_LOAD, 10'd0, 10'd0, 1'b1, 16'h0000);
        send_req(mfge_pkg::REQ_EDGE, 10'd0, 10'd5, 1'b0, 16'h0040);
        send_req(mfge_pkg::REQ_FLIP, 10'd5, 10'd0, 1'b0, 16'h0000);
        drain_results();
        write_reg(CFG_FIXED_EN, 1'b0);
        write_reg(CFG_FIXED_SPIN, 1'b0);

        // A gap-free burst of appends, then flips that walk the whole list.
        tx_calm = 1'b1;
        send_req(mfge_pkg::REQ_CLEAR, 10'd0, 10'd0, 1'b0, 16'h0000);
        for (int k = 0; k < 12; k++)
            send_req(mfge_pkg::REQ_EDGE, pick_node(), pick_node(), 1'b0, 16'($urandom));
        send_req(mfge_pkg::REQ_FLIP, 10'd3, 10'd0, 1'b0, 16'h0000);
        send_req(mfge_pkg::REQ_FLIP, 10'd1023, 10'd0, 1'b0, 16'h0000);
        send_req(mfge_pkg::REQ_CLEAR, 10'd0, 10'd0, 1'b0, 16'h0000);
        tx_calm = 1'b0;
        drain_results();

        for (int phase = 0; phase < 4; phase++)
        begin
            write_reg(CFG_FIXED_EN, 1'(phase));
            write_reg(CFG_FIXED_SPIN, 1'(phase >> 1));
            for (int k = 0; k < 26; k++)
            begin
                if (k % 12 == 0)
                    tx_calm = ($urandom_range(0, 3) == 0);
                random_req();
            end
            drain_results();
        end

        repeat (30) @(negedge clk);
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
